// ===== rtl/cst_pkg.sv =====
// Shared types and constants for the client session table.
// Used by cst_regs and the top level; depends on nothing.
`default_nettype none

package cst_pkg;

	localparam int ENTRIES = 16;
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = 5;
	localparam int ADDR_W = 32;
	localparam int LEVEL_W = 8;
	localparam int TIME_W = 32;
	localparam int LIMIT_W = 22;
	localparam int SECONDS_PER_MINUTE = 60;

	localparam logic [1:0] CMD_ADD = 2'd0;
	localparam logic [1:0] CMD_CHECK = 2'd1;
	localparam logic [1:0] CMD_CONN = 2'd2;
	localparam logic [1:0] CMD_PURGE = 2'd3;

	localparam logic REG_MAX_CLIENTS = 1'b0;
	localparam logic REG_IDLE_MINUTES = 1'b1;

	localparam logic [7:0] MAX_CLIENTS_RESET = 8'd16;
	localparam logic [15:0] IDLE_MINUTES_RESET = 16'd5;

	typedef struct packed {
		logic [7:0] max_clients;
		logic [15:0] idle_minutes;
	} cfg_t;

	typedef struct packed {
		logic [ADDR_W-1:0] addr;
		logic [LEVEL_W-1:0] level;
		logic [TIME_W-1:0] stamp;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

endpackage

`default_nettype wire

// ===== rtl/client_session_table_idle_timeout_core.sv =====
// Top level of the client session table with idle timeout.
// Depends on cst_pkg, cst_regs and cst_ram.
//
// Channel   Signals                                              Handshake
// request   start, busy, cmd, client_addr, access_level,         start && !busy
//           now_seconds
// result    done, ok, active_count                               done, one cycle
// config    psel, penable, pwrite, paddr, pwdata, prdata, pready APB, pready = 1
//
// A request runs through a scan of every entry, a drain state and a finish
// state. The scan is paced by the single read port of the entry RAM,
// which delivers one entry per cycle to the read-modify-write stage.
// The result appears on the cycle after the finish state, in the same cycle
// in which busy falls, so a new request may be accepted while it is shown.
// Reset clears all valid bits at once; the RAM needs no clearing pass.
// The receiver cannot stall the result, so nothing holds back the scan.
`default_nettype none

module client_session_table_idle_timeout_core
	import cst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	output logic busy,
	input wire logic [1:0] cmd,
	input wire logic [31:0] client_addr,
	input wire logic [7:0] access_level,
	input wire logic [31:0] now_seconds,
	output logic done,
	output logic ok,
	output logic [4:0] active_count,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);

	localparam logic [1:0] ST_IDLE = 2'd0;
	localparam logic [1:0] ST_SCAN = 2'd1;
	localparam logic [1:0] ST_LAST = 2'd2;
	localparam logic [1:0] ST_DONE = 2'd3;

	cfg_t cfg;

	cst_regs u_regs (
		.clk(clk),
		.arst_n(arst_n),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready),
		.cfg(cfg)
	);

	logic [1:0] state_q;
	logic [IDX_W-1:0] idx_q;
	logic [ENTRIES-1:0] valid_q;

	// Request fields, held for the whole scan.
	logic [1:0] cmd_q;
	logic [ADDR_W-1:0] addr_q;
	logic [LEVEL_W-1:0] level_q;
	logic [TIME_W-1:0] now_q;
	logic [LIMIT_W-1:0] limit_q;

	// Scan accumulators.
	logic found_q;
	logic hit_q;
	logic [CNT_W-1:0] cnt_q;
	logic free_found_q;
	logic [IDX_W-1:0] free_idx_q;

	// Read-modify-write stage: the entry read in the previous cycle.
	logic vld_s1;
	logic [IDX_W-1:0] idx_s1;

	logic accept;
	logic rd_en;
	entry_t rd_entry;
	logic ram_we;
	logic [IDX_W-1:0] ram_waddr;
	entry_t ram_wdata;

	assign busy = (state_q != ST_IDLE);
	assign accept = start && !busy;
	assign rd_en = (state_q == ST_SCAN);

	cst_ram #(
		.WIDTH(ENTRY_W),
		.DEPTH(ENTRIES)
	) u_ram (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re(rd_en),
		.raddr(idx_q),
		.rdata(rd_entry)
	);

	// Per-entry decisions. A refreshing add ages the entry with the new stamp,
	// so a matched entry survives only when the idle limit is nonzero.
	logic cur_valid;
	logic match;
	logic is_add;
	logic [TIME_W-1:0] eff_stamp;
	logic [TIME_W-1:0] age;
	logic live;
	logic check_hit;
	logic new_valid;
	logic entry_wr;
	logic entry_ok;

	always_comb begin
		cur_valid = valid_q[idx_s1];
		match = (rd_entry.addr == addr_q);
		is_add = (cmd_q == CMD_ADD);
		eff_stamp = (is_add && match) ? now_q : rd_entry.stamp;
		age = now_q - eff_stamp;
		live = (age < TIME_W'(limit_q));
		check_hit = cur_valid && match && (rd_entry.level >= level_q);
		new_valid = cur_valid;
		entry_wr = 1'b0;
		entry_ok = 1'b0;
		unique case (cmd_q)
			CMD_ADD: begin
				new_valid = cur_valid && live;
				entry_wr = cur_valid && match && live;
			end
			CMD_CHECK: begin
				new_valid = cur_valid && !(check_hit && !live);
				entry_wr = check_hit && live;
				entry_ok = check_hit && live;
			end
			CMD_CONN: begin
				entry_ok = cur_valid && match;
			end
			CMD_PURGE: begin
				new_valid = cur_valid && live;
			end
			default: ;
		endcase
	end

	// Insertion at the first slot left free by the scan.
	logic insert;
	logic result_ok;

	always_comb begin
		insert = (cmd_q == CMD_ADD) && !found_q && free_found_q &&
			(8'(cnt_q) < cfg.max_clients);
		unique case (cmd_q)
			CMD_ADD: result_ok = found_q || insert;
			CMD_PURGE: result_ok = 1'b1;
			default: result_ok = hit_q;
		endcase
	end

	// The scan writes back the entry it read in the previous cycle, while the
	// read port already fetches the next index, so the two never collide.
	always_comb begin
		ram_we = 1'b0;
		ram_waddr = idx_s1;
		ram_wdata.addr = rd_entry.addr;
		ram_wdata.level = is_add ? level_q : rd_entry.level;
		ram_wdata.stamp = now_q;
		if (vld_s1) begin
			ram_we = entry_wr;
		end else if (state_q == ST_DONE) begin
			ram_we = insert;
			ram_waddr = free_idx_q;
			ram_wdata.addr = addr_q;
			ram_wdata.level = level_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			idx_q <= '0;
			valid_q <= '0;
			vld_s1 <= 1'b0;
			found_q <= 1'b0;
			hit_q <= 1'b0;
			cnt_q <= '0;
			free_found_q <= 1'b0;
			done <= 1'b0;
		end else begin
			done <= 1'b0;
			vld_s1 <= rd_en;
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						state_q <= ST_SCAN;
						idx_q <= '0;
						found_q <= 1'b0;
						hit_q <= 1'b0;
						cnt_q <= '0;
						free_found_q <= 1'b0;
					end
				end
				ST_SCAN: begin
					idx_q <= idx_q + IDX_W'(1);
					if (idx_q == IDX_W'(ENTRIES - 1)) begin
						state_q <= ST_LAST;
					end
				end
				ST_LAST: begin
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
					done <= 1'b1;
					if (insert) begin
						valid_q[free_idx_q] <= 1'b1;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
			if (vld_s1) begin
				valid_q[idx_s1] <= new_valid;
				if (cur_valid && match) begin
					found_q <= 1'b1;
				end
				if (entry_ok) begin
					hit_q <= 1'b1;
				end
				if (new_valid) begin
					cnt_q <= cnt_q + CNT_W'(1);
				end
				if (!new_valid && !free_found_q) begin
					free_found_q <= 1'b1;
				end
			end
		end
	end

	// Payload registers carry no reset.
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q <= cmd;
			addr_q <= client_addr;
			level_q <= access_level;
			now_q <= now_seconds;
			limit_q <= {6'd0, cfg.idle_minutes} * LIMIT_W'(SECONDS_PER_MINUTE);
		end
		idx_s1 <= idx_q;
		if (vld_s1 && !new_valid && !free_found_q) begin
			free_idx_q <= idx_s1;
		end
		if (state_q == ST_DONE) begin
			ok <= result_ok;
			active_count <= cnt_q + CNT_W'(insert);
		end
	end

`ifndef NO_ASSERTIONS
	a_no_rw_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		(ram_we && rd_en) |-> (ram_waddr != idx_q))
		else $error("entry RAM write and read hit the same index");

	a_done_pulse: assert property (@(posedge clk) disable iff (!arst_n)
		done |=> !done)
		else $error("result strobe lasted more than one cycle");

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> (busy && (idx_q == '0)))
		else $error("accepted request did not start a scan");

	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> (active_count == CNT_W'($countones(valid_q))))
		else $error("reported count does not match the valid bits");
`endif

endmodule

`default_nettype wire

// ===== rtl/cst_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module cst_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic re,
	input wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// ===== rtl/cst_regs.sv =====
// APB-style configuration registers of the session table.
// Depends on cst_pkg for the register layout and reset values.
`default_nettype none

module cst_regs
	import cst_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	input wire logic psel,
	input wire logic penable,
	input wire logic pwrite,
	input wire logic [2:0] paddr,
	input wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready,
	output cfg_t cfg
);

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel && penable && pwrite;
	assign cfg = cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.max_clients <= MAX_CLIENTS_RESET;
			cfg_q.idle_minutes <= IDLE_MINUTES_RESET;
		end else if (wr_en) begin
			unique case (paddr[2])
				REG_MAX_CLIENTS: cfg_q.max_clients <= pwdata[7:0];
				REG_IDLE_MINUTES: cfg_q.idle_minutes <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// The low address bits select a byte within the word and are ignored.
	always_comb begin
		unique case (paddr[2])
			REG_MAX_CLIENTS: prdata = {24'd0, cfg_q.max_clients};
			REG_IDLE_MINUTES: prdata = {16'd0, cfg_q.idle_minutes};
			default: prdata = 32'd0;
		endcase
	end

endmodule

`default_nettype wire
